### sv/battery_median_alarm_switch_macros.svh
// Assertion macros shared by the battery median alarm switch RTL.
// Included by the modules that carry concurrent assertions; needs i_clk and i_rst_n.
`ifndef BATTERY_MEDIAN_ALARM_SWITCH_MACROS_SVH
`define BATTERY_MEDIAN_ALARM_SWITCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bmas_pkg.sv
// Package for the battery median alarm switch: types, codes and fixed constants.
// Used by bmas_measure, bmas_switch_ctl and battery_median_alarm_switch.
`default_nettype none

package bmas_pkg;

    localparam int MV_W        = 14;
    localparam int VOLT_W      = 8;
    localparam int LEVEL_W     = 8;
    localparam int ALARM_W     = 3;
    localparam int CMD_W       = 2;
    localparam int ACTION_W    = 2;
    localparam int THR_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    typedef logic [MV_W-1:0]     t_mv;
    typedef logic [VOLT_W-1:0]   t_volt;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [ALARM_W-1:0]  t_alarm;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [THR_W-1:0]    t_thr;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_level LEVEL_FULL = 8'hC8;

    // Division by 100 as a multiply by ceil(2^19 / 100); exact for all 14-bit values.
    localparam int          TENTHS_SHIFT = 19;
    localparam int          TENTHS_MUL_W = 13;
    localparam logic [12:0] TENTHS_MUL   = 13'd5243;

    localparam t_cmd CMD_OFF    = 2'd0;
    localparam t_cmd CMD_ON     = 2'd1;
    localparam t_cmd CMD_TOGGLE = 2'd2;

    localparam t_action ACT_ON_ALARM  = 2'd0;
    localparam t_action ACT_OFF_ALARM = 2'd1;
    localparam t_action ACT_TOGGLE    = 2'd2;
    localparam t_action ACT_NONE      = 2'd3;

    localparam t_cfg_idx REG_ALARM_MASK    = 3'd0;
    localparam t_cfg_idx REG_MIN_THRESHOLD = 3'd1;
    localparam t_cfg_idx REG_THRESHOLD_ONE = 3'd2;
    localparam t_cfg_idx REG_THRESHOLD_TWO = 3'd3;
    localparam t_cfg_idx REG_SWITCH_ACTION = 3'd4;

    typedef struct packed {
        t_alarm  alarm_enable_mask;
        t_thr    min_threshold;
        t_thr    threshold_one;
        t_thr    threshold_two;
        t_action switch_action;
    } t_cfg;

    typedef struct packed {
        t_mv    median_mv;
        t_volt  voltage_tenths;
        t_level level;
    } t_meas;

    typedef struct packed {
        logic   first_pending;
        t_alarm prev_alarm;
        logic   relay_on;
    } t_ctl_state;

    typedef struct packed {
        t_alarm alarm_bits;
        logic   command_valid;
        t_cmd   command;
        logic   relay_on;
    } t_ctl_result;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic   relay_on;
        t_cmd   command;
        logic   command_valid;
        t_alarm alarm_bits;
        t_level level;
        t_volt  voltage_tenths;
        t_mv    median_mv;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

### sv/battery_median_alarm_switch.sv
// Top level of the battery median alarm switch: handshake, registers and state.
// Depends on bmas_pkg, bmas_measure, bmas_switch_ctl and the assertion macro header.
//
// Usage: each transfer on the slave stream carries one millivolt sample in
// s_axis_tdata[13:0]. Each sample gives exactly one result transfer on the master
// stream with the median of the last three samples, the voltage in tenths, the
// 0 to 200 level, the alarm word, the relay command and the tracked relay state.
// Thresholds and the switch action are written on the configuration port while
// no sample is in flight.
// Path: the sample is held in the input register, and the result is then
// loaded into the result register, which drives o_m_axis_tvalid.
// Throughput: one sample per cycle while tready stays high; the median, divide
// and level multiply all sit in the single logic stage between the two registers.
// Reset: synchronous and active low; it clears the settings and the control
// registers, empties both stages and marks the next sample as the first, which
// fills the history.
// Stall: while the receiver holds tready low the result register keeps its
// item, one more sample can still enter the input register, and after that
// s_axis_tready drops until the result is taken.
`default_nettype none

`include "battery_median_alarm_switch_macros.svh"

module battery_median_alarm_switch #(
    parameter int EMPTY_MV = 2800,
    parameter int FULL_MV  = 3300
) (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    input  var logic                                i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // Bits from the lowest up: sample_mv[13:0], zero fill[15:14].
    input  var logic [bmas_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  var logic                                i_m_axis_tready,
    // Bits from the lowest up: median_mv[13:0], voltage_tenths[21:14], level[29:22],
    // alarm_bits[32:30], command_valid[33], command[35:34], relay_on[36], zero fill.
    output logic [bmas_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    input  var logic                                i_cfg_we,
    input  var logic [bmas_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  var logic [bmas_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bmas_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    t_mv         r_sample;
    logic        r_out_valid;
    t_result     r_out;
    t_mv         r_hist0;
    t_mv         r_hist1;
    logic        r_first;
    t_alarm      r_prev_alarm;
    logic        r_relay;

    logic        in_accept;
    logic        out_load;
    t_mv         n_hist0;
    t_mv         n_hist1;
    t_mv         n_hist2;
    t_meas       meas;
    t_ctl_state  ctl_state;
    t_ctl_result ctl;
    t_result     n_out;

    assign out_load        = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || out_load;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // The first sample after reset fills the whole history.
    always_comb begin
        n_hist0 = r_sample;
        n_hist1 = r_first ? r_sample : r_hist0;
        n_hist2 = r_first ? r_sample : r_hist1;
    end

    bmas_measure #(
        .EMPTY_MV (EMPTY_MV),
        .FULL_MV  (FULL_MV)
    ) u_measure (
        .i_a    (n_hist0),
        .i_b    (n_hist1),
        .i_c    (n_hist2),
        .o_meas (meas)
    );

    always_comb begin
        ctl_state.first_pending = r_first;
        ctl_state.prev_alarm    = r_prev_alarm;
        ctl_state.relay_on      = r_relay;
    end

    bmas_switch_ctl u_switch_ctl (
        .i_volt   (meas.voltage_tenths),
        .i_cfg    (r_cfg),
        .i_state  (ctl_state),
        .o_result (ctl)
    );

    always_comb begin
        n_out.median_mv      = meas.median_mv;
        n_out.voltage_tenths = meas.voltage_tenths;
        n_out.level          = meas.level;
        n_out.alarm_bits     = ctl.alarm_bits;
        n_out.command_valid  = ctl.command_valid;
        n_out.command        = ctl.command;
        n_out.relay_on       = ctl.relay_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ALARM_MASK:    r_cfg.alarm_enable_mask <= i_cfg_data[ALARM_W-1:0];
                REG_MIN_THRESHOLD: r_cfg.min_threshold     <= i_cfg_data[THR_W-1:0];
                REG_THRESHOLD_ONE: r_cfg.threshold_one     <= i_cfg_data[THR_W-1:0];
                REG_THRESHOLD_TWO: r_cfg.threshold_two     <= i_cfg_data[THR_W-1:0];
                REG_SWITCH_ACTION: r_cfg.switch_action     <= i_cfg_data[ACTION_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_first      <= 1'b1;
            r_prev_alarm <= '0;
            r_relay      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_first      <= 1'b0;
                r_prev_alarm <= ctl.alarm_bits;
                r_relay      <= ctl.relay_on;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_s_axis_tdata[MV_W-1:0];
        end
        if (out_load) begin
            r_out   <= n_out;
            r_hist0 <= n_hist0;
            r_hist1 <= n_hist1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), r_out};

    `BMAS_ASSERT_NEXT(a_cmd_flips_relay, out_load && ctl.command_valid,
        r_relay != $past(r_relay), "issued command did not change the relay state")
    `BMAS_ASSERT_NEXT(a_no_cmd_keeps_relay, out_load && !ctl.command_valid,
        $stable(r_relay), "relay state changed without a command")
    `BMAS_ASSERT_NEXT(a_first_cleared, out_load, !r_first,
        "first sample flag still set after a sample was processed")
    `BMAS_ASSERT_NOW(a_idle_cmd_zero, r_out_valid && !r_out.command_valid,
        r_out.command == CMD_OFF, "command field not zero without a command")
    `BMAS_ASSERT_NEXT(a_in_reg_held, r_in_valid && !out_load,
        r_in_valid && $stable(r_sample), "waiting sample was lost or overwritten")

endmodule

`default_nettype wire

### sv/bmas_measure.sv
// Median of three samples, voltage in tenths and the 0 to 200 level.
// Depends on bmas_pkg.
`default_nettype none

module bmas_measure #(
    parameter int EMPTY_MV = 2800,
    parameter int FULL_MV  = 3300
) (
    input  var bmas_pkg::t_mv   i_a,
    input  var bmas_pkg::t_mv   i_b,
    input  var bmas_pkg::t_mv   i_c,
    output bmas_pkg::t_meas     o_meas
);
    import bmas_pkg::*;

    // The level quotient (median - empty) * 200 / span is a single multiply by a
    // rounded-up reciprocal; the shift is large enough that it is always exact.
    localparam int SPAN      = (FULL_MV > EMPTY_MV) ? (FULL_MV - EMPTY_MV) : 1;
    localparam int SPAN_BITS = $clog2(SPAN + 1);
    localparam int LVL_SHIFT = 2 * SPAN_BITS;
    localparam longint unsigned LVL_MUL =
        ((longint'(200) << LVL_SHIFT) + longint'(SPAN) - 1) / longint'(SPAN);
    localparam int LVL_MUL_W = $clog2(LVL_MUL + 1);
    localparam int LVL_PROD_W = MV_W + LVL_MUL_W;
    localparam int TEN_PROD_W = MV_W + TENTHS_MUL_W;

    t_mv                     lo_ab;
    t_mv                     hi_ab;
    t_mv                     med;
    t_mv                     diff;
    logic [TEN_PROD_W-1:0]   ten_prod;
    logic [LVL_PROD_W-1:0]   lvl_prod;
    t_level                  level;

    always_comb begin
        lo_ab = (i_a < i_b) ? i_a : i_b;
        hi_ab = (i_a < i_b) ? i_b : i_a;
        med   = (hi_ab < i_c) ? hi_ab : ((lo_ab > i_c) ? lo_ab : i_c);
    end

    assign ten_prod = TEN_PROD_W'(med) * TEN_PROD_W'(TENTHS_MUL);
    assign diff     = med - MV_W'(EMPTY_MV);
    assign lvl_prod = LVL_PROD_W'(diff) * LVL_PROD_W'(LVL_MUL);

    always_comb begin
        priority if (med <= MV_W'(EMPTY_MV)) begin
            level = '0;
        end else if (med >= MV_W'(FULL_MV)) begin
            level = LEVEL_FULL;
        end else begin
            level = lvl_prod[LVL_SHIFT +: LEVEL_W];
        end
    end

    assign o_meas.median_mv      = med;
    assign o_meas.voltage_tenths = ten_prod[TENTHS_SHIFT +: VOLT_W];
    assign o_meas.level          = level;

endmodule

`default_nettype wire

### sv/bmas_switch_ctl.sv
// Threshold alarms and the relay command decision for one sample.
// Depends on bmas_pkg.
`default_nettype none

module bmas_switch_ctl (
    input  var bmas_pkg::t_volt      i_volt,
    input  var bmas_pkg::t_cfg       i_cfg,
    input  var bmas_pkg::t_ctl_state i_state,
    output bmas_pkg::t_ctl_result    o_result
);
    import bmas_pkg::*;

    t_alarm alarm;
    logic   alarm_any;
    logic   cand_valid;
    t_cmd   cand;
    logic   issue;

    always_comb begin
        alarm[0] = i_cfg.alarm_enable_mask[0] && (i_volt <= i_cfg.min_threshold);
        alarm[1] = i_cfg.alarm_enable_mask[1] && (i_volt <= i_cfg.threshold_one);
        alarm[2] = i_cfg.alarm_enable_mask[2] && (i_volt <= i_cfg.threshold_two);
    end

    assign alarm_any = |alarm;

    always_comb begin
        cand_valid = 1'b0;
        cand       = CMD_OFF;
        unique case (i_cfg.switch_action)
            ACT_ON_ALARM: begin
                cand_valid = 1'b1;
                cand       = alarm_any ? CMD_ON : CMD_OFF;
            end
            ACT_OFF_ALARM: begin
                cand_valid = 1'b1;
                cand       = alarm_any ? CMD_OFF : CMD_ON;
            end
            ACT_TOGGLE: begin
                cand_valid = alarm_any != (|i_state.prev_alarm);
                cand       = CMD_TOGGLE;
            end
            ACT_NONE: begin
                cand_valid = 1'b0;
                cand       = CMD_OFF;
            end
        endcase
    end

    assign issue = !i_state.first_pending && cand_valid
                   && ((cand == CMD_TOGGLE) || (cand[0] != i_state.relay_on));

    always_comb begin
        o_result.alarm_bits    = alarm;
        o_result.command_valid = issue;
        o_result.command       = issue ? cand : CMD_OFF;
        if (!issue) begin
            o_result.relay_on = i_state.relay_on;
        end else if (cand == CMD_TOGGLE) begin
            o_result.relay_on = !i_state.relay_on;
        end else begin
            o_result.relay_on = cand[0];
        end
    end

endmodule

`default_nettype wire
